// ===== src/masked_pattern_search_macros.svh =====
// assertion macros for the masked pattern search block
// used by modules that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef MASKED_PATTERN_SEARCH_MACROS_SVH
`define MASKED_PATTERN_SEARCH_MACROS_SVH

`ifndef SYNTH
// property check, disabled during reset
`define MPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that holds at every clock edge out of reset
`define MPS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`else
`define MPS_ASSERT(lbl, prop, msg)
`define MPS_CHECK(lbl, cond, msg)
`endif

`endif

// ===== src/mps_pkg.sv =====
// shared types and constants for the masked pattern search block
// no dependencies; imported by every module of the block
package mps_pkg;

  localparam int MAX_PATTERN    = 16;
  localparam int BYTES_PER_ITEM = 8;
  localparam int OFFSET_BITS    = 32;

  localparam int HIST_BYTES  = MAX_PATTERN - 1;
  localparam int STRM_BYTES  = HIST_BYTES + BYTES_PER_ITEM;
  localparam int STRM_IDX_W  = $clog2(STRM_BYTES);
  localparam int LANE_IDX_W  = (BYTES_PER_ITEM > 1) ? $clog2(BYTES_PER_ITEM) : 1;
  localparam int PAT_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = 5;
  localparam int CNT_W       = 4;
  localparam int WORD_W      = 64;
  localparam int CARE_W      = 16;
  localparam int ADDR_W      = 5;
  localparam int REG_SEL_LSB = 3;

  // register map, one 64-bit slot per register
  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_CARE_MASK      = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic [CNT_W-1:0]  byte_count;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] match_offset;
  } out_item_t;

  // pattern aligned to the window end: entry m is compared with the byte m back
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] win_pat;
    logic [MAX_PATTERN-1:0]      win_care;
    logic [LEN_W-1:0]            len;
  } cfg_t;

  // lane results of one item, handed to the merge stage
  typedef struct packed {
    logic                      valid;
    logic [BYTES_PER_ITEM-1:0] hit;
    logic [OFFSET_BITS-1:0]    seen;
    logic                      last;
  } lane_res_t;

endpackage

// ===== src/mps_cfg.sv =====
// configuration registers with bus port, plus window-aligned pattern and care bits
// depends on mps_pkg
module mps_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mps_pkg::ADDR_W-1:0] paddr,
  input  logic [mps_pkg::WORD_W-1:0] pwdata,
  output logic [mps_pkg::WORD_W-1:0] prdata,
  output logic                       pready,
  output mps_pkg::cfg_t              cfg_o
);
  import mps_pkg::*;

  logic [WORD_W-1:0] pat_low_q, pat_high_q;
  logic [CARE_W-1:0] care_q;
  logic [LEN_W-1:0]  len_q;
  logic              wr_en;
  cfg_reg_e          reg_sel;
  logic [LEN_W-1:0]  len_eff;
  logic [7:0]        pat_bytes [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] care_bits;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_e'(paddr[REG_SEL_LSB +: 2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '0;
      len_q      <= LEN_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_PATTERN_LOW:    pat_low_q  <= pwdata;
        REG_PATTERN_HIGH:   pat_high_q <= pwdata;
        REG_CARE_MASK:      care_q     <= pwdata[CARE_W-1:0];
        REG_PATTERN_LENGTH: len_q      <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_PATTERN_LOW:    prdata = pat_low_q;
      REG_PATTERN_HIGH:   prdata = pat_high_q;
      REG_CARE_MASK:      prdata = WORD_W'(care_q);
      REG_PATTERN_LENGTH: prdata = WORD_W'(len_q);
      default:            prdata = '0;
    endcase
  end

  // length clamp: zero acts as one, large values as the maximum
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_q;
    end
  end

  // pattern bytes in order
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < WORD_W / 8) begin
        pat_bytes[i] = pat_low_q[8*(i % (WORD_W / 8)) +: 8];
      end else begin
        pat_bytes[i] = pat_high_q[8*(i % (WORD_W / 8)) +: 8];
      end
      care_bits[i] = (i < CARE_W) ? care_q[i % CARE_W] : 1'b0;
    end
  end

  // align so that entry m faces the stream byte m positions before the window end
  always_comb begin
    logic [PAT_IDX_W-1:0] pidx;
    pidx = '0;
    for (int m = 0; m < MAX_PATTERN; m++) begin
      pidx = PAT_IDX_W'(int'(len_eff) - 1 - m);
      cfg_o.win_pat[m] = pat_bytes[pidx];
      cfg_o.win_care[m] = (m < int'(len_eff)) ? care_bits[pidx] : 1'b0;
    end
    cfg_o.len = len_eff;
  end

endmodule

// ===== src/mps_lane.sv =====
// one window comparator: masked compare of a pattern against one window of stream bytes
// depends on mps_pkg
module mps_lane (
  input  logic [7:0]                      win_i [mps_pkg::MAX_PATTERN],
  input  logic [mps_pkg::MAX_PATTERN-1:0][7:0] pat_i,
  input  logic [mps_pkg::MAX_PATTERN-1:0] care_i,
  output logic                            match_o
);
  import mps_pkg::*;

  logic [MAX_PATTERN-1:0] ok;

  // a byte passes when it is a wildcard or equal
  always_comb begin
    for (int m = 0; m < MAX_PATTERN; m++) begin
      ok[m] = !care_i[m] || (win_i[m] == pat_i[m]);
    end
  end

  assign match_o = &ok;

endmodule

// ===== src/mps_lanes.sv =====
// input stage: stream history, byte count and eight window comparator lanes
// depends on mps_pkg and mps_lane
module mps_lanes (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mps_pkg::in_item_t   in_item_i,
  input  mps_pkg::cfg_t       cfg_i,
  input  logic                s2_go_i,
  output mps_pkg::lane_res_t  res_o
);
  import mps_pkg::*;

  logic [7:0]                hist_q [HIST_BYTES];
  logic [7:0]                hist_d [HIST_BYTES];
  logic [OFFSET_BITS-1:0]    seen_q, seen_d;
  logic [7:0]                strm [STRM_BYTES];
  logic [CNT_W-1:0]          cnt;
  logic [BYTES_PER_ITEM-1:0] lane_match, lane_ok;
  logic                      accept, stage_free;
  logic [OFFSET_BITS:0]      seen_sum;

  logic                      res_valid_q;
  logic [BYTES_PER_ITEM-1:0] res_hit_q;
  logic [OFFSET_BITS-1:0]    res_seen_q;
  logic                      res_last_q;

  // handshake: take an item whenever the result stage has room
  assign stage_free = !res_valid_q || s2_go_i;
  assign in_stall_o = !stage_free;
  assign accept     = in_valid_i && stage_free;

  // byte count clamp
  assign cnt = (in_item_i.byte_count > CNT_W'(BYTES_PER_ITEM)) ? CNT_W'(BYTES_PER_ITEM)
                                                                : in_item_i.byte_count;

  // stream view: history oldest first, then the new bytes
  always_comb begin
    for (int j = 0; j < HIST_BYTES; j++) begin
      strm[j] = hist_q[HIST_BYTES - 1 - j];
    end
    for (int k = 0; k < BYTES_PER_ITEM; k++) begin
      strm[HIST_BYTES + k] = in_item_i.data_word[8*k +: 8];
    end
  end

  // comparator lanes, lane k checks the window ending at new byte k
  for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
    logic [7:0] win [MAX_PATTERN];
    for (genvar m = 0; m < MAX_PATTERN; m++) begin : g_tap
      assign win[m] = strm[HIST_BYTES + k - m];
    end
    mps_lane u_lane (
      .win_i   (win),
      .pat_i   (cfg_i.win_pat),
      .care_i  (cfg_i.win_care),
      .match_o (lane_match[k])
    );
    // byte present and whole window inside the stream
    assign lane_ok[k] = (CNT_W'(k) < cnt) &&
                        (({1'b0, seen_q} + (OFFSET_BITS+1)'(k + 1)) >=
                         (OFFSET_BITS+1)'(cfg_i.len));
  end

  // history and byte count after the item
  assign seen_sum = {1'b0, seen_q} + (OFFSET_BITS+1)'(cnt);
  always_comb begin
    logic [STRM_IDX_W-1:0] idx;
    idx = '0;
    for (int m = 0; m < HIST_BYTES; m++) begin
      idx = STRM_IDX_W'(HIST_BYTES - 1 + int'(cnt) - m);
      hist_d[m] = in_item_i.last ? 8'h00 : strm[idx];
    end
    if (in_item_i.last) begin
      seen_d = '0;
    end else if (seen_sum[OFFSET_BITS]) begin
      seen_d = '1;
    end else begin
      seen_d = seen_sum[OFFSET_BITS-1:0];
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < HIST_BYTES; m++) begin
        hist_q[m] <= 8'h00;
      end
      seen_q <= '0;
    end else if (accept) begin
      hist_q <= hist_d;
      seen_q <= seen_d;
    end
  end

  // result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (stage_free) begin
      res_valid_q <= in_valid_i;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_hit_q  <= lane_match & lane_ok;
      res_seen_q <= seen_q;
      res_last_q <= in_item_i.last;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.hit   = res_hit_q;
  assign res_o.seen  = res_seen_q;
  assign res_o.last  = res_last_q;

endmodule

// ===== src/mps_merge.sv =====
// merge stage: picks the earliest lane hit, forms the offset, holds the output register
// depends on mps_pkg and the assertion macro header
`include "masked_pattern_search_macros.svh"
module mps_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mps_pkg::lane_res_t  s2_i,
  input  logic [mps_pkg::LEN_W-1:0] len_i,
  output logic                s2_go_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mps_pkg::out_item_t  out_item_o
);
  import mps_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic                   done_q, done_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  logic                   any_hit, has_result, out_free, load;
  logic [LANE_IDX_W-1:0]  sel;
  logic [OFFSET_BITS:0]   end_pos;
  logic [OFFSET_BITS-1:0] offset;

  // earliest hit lane
  assign any_hit = |s2_i.hit;
  always_comb begin
    sel = '0;
    for (int k = BYTES_PER_ITEM - 1; k >= 0; k--) begin
      if (s2_i.hit[k]) begin
        sel = LANE_IDX_W'(k);
      end
    end
  end

  // offset of the window start, pinned at all ones once the count saturates
  assign end_pos = {1'b0, s2_i.seen} + (OFFSET_BITS+1)'(sel) + (OFFSET_BITS+1)'(1);
  always_comb begin
    logic [OFFSET_BITS:0] start;
    start = end_pos - (OFFSET_BITS+1)'(len_i);
    if (end_pos >= {1'b0, OFF_MAX}) begin
      offset = OFF_MAX;
    end else begin
      offset = start[OFFSET_BITS-1:0];
    end
  end

  // flow: an item with no result always moves on; one with a result needs a free slot
  assign has_result = !done_q && (any_hit || s2_i.last);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_go_o    = s2_i.valid && (!has_result || out_free);
  assign load       = s2_go_o && has_result;

  // match-done tracking per region
  always_comb begin
    done_d = done_q;
    if (s2_go_o) begin
      if (s2_i.last) begin
        done_d = 1'b0;
      end else if (load && any_hit) begin
        done_d = 1'b1;
      end
    end
  end

  // output register next value
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (load) begin
      out_valid_d        = 1'b1;
      out_d.found        = any_hit;
      out_d.match_offset = any_hit ? offset : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `MPS_CHECK(a_sel_hits, !s2_i.valid || !any_hit || s2_i.hit[sel], "selected lane has no hit")
  `MPS_ASSERT(a_nf_zero, out_valid_q && !out_q.found |-> out_q.match_offset == '0, "bad nf offset")
  `MPS_ASSERT(a_held, s2_i.valid && !s2_go_o |=> s2_i.valid && $stable(s2_i.hit), "result lost")
  `MPS_ASSERT(a_done_set, load && any_hit && !s2_i.last |=> done_q, "match did not close the region")

endmodule

// ===== src/masked_pattern_search.sv =====
// top level of the masked byte signature scanner
// depends on mps_pkg, mps_cfg, mps_lanes (with mps_lane) and mps_merge
//
// Scans a byte stream arriving eight bytes per transfer for the first window that
// matches the configured pattern under its care mask, and reports one result per
// region: the start offset of the earliest match, or not-found on the last transfer.
// A new input transfer is taken every cycle unless in_stall_o is high; eight window
// comparator lanes check all window ends of a transfer at once and a merge stage picks
// the earliest hit. A result is registered first in the lane result stage and then in
// the output register; two transfers in flight keep the input moving while a result
// waits on a stalled output. After a match, the rest of the region is consumed with
// no further result. Configuration registers sit at byte addresses 0, 8, 16, 24 and
// are to be written while idle.
module masked_pattern_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mps_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mps_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mps_pkg::ADDR_W-1:0] paddr,
  input  logic [mps_pkg::WORD_W-1:0] pwdata,
  output logic [mps_pkg::WORD_W-1:0] prdata,
  output logic                       pready
);
  import mps_pkg::*;

  cfg_t      cfg;
  lane_res_t lane_res;
  logic      s2_go;

  // configuration registers
  mps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // history and comparator lanes
  mps_lanes u_lanes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg),
    .s2_go_i    (s2_go),
    .res_o      (lane_res)
  );

  // earliest hit and output register
  mps_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_i        (lane_res),
    .len_i       (cfg.len),
    .s2_go_o     (s2_go),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sim/mps_scan_check.sv =====
`timescale 1ns / 100ps
// scoreboard for the masked pattern search block: tracks register writes,
// predicts the scan result of each input transfer and checks the output channel
// depends on mps_pkg
module mps_scan_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  mps_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  mps_pkg::out_item_t          out_item_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [mps_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [mps_pkg::WORD_W-1:0]  pwdata_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          scanned_o
);
  import mps_pkg::*;

  // shadow copy of the registers
  logic [WORD_W-1:0] pat_lo_q;
  logic [WORD_W-1:0] pat_hi_q;
  logic [CARE_W-1:0] care_q;
  logic [LEN_W-1:0]  len_q;

  // stream state: newest byte in entry 0
  logic [MAX_PATTERN-1:0][7:0] recent_q;
  logic [OFFSET_BITS-1:0]      seen_q;
  logic                        matched_q;

  out_item_t results_q[$];
  int        fails;
  int        scanned;

  // does the window ending at the newest byte fit the pattern under the care mask
  function automatic bit window_hit(int unsigned span);
    logic [2*WORD_W-1:0] pat;
    pat = {pat_hi_q, pat_lo_q};
    for (int i = 0; i < span; i++) begin
      if (care_q[i] && recent_q[span-1-i] != pat[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // push the bytes of one transfer through the window, stop at the first hit
  task automatic scan_item(input in_item_t it, output bit has_res, output out_item_t res);
    int unsigned span;
    int unsigned n_take;
    has_res = 1'b0;
    res     = '0;
    span    = (len_q == 0) ? 1 : (len_q > MAX_PATTERN) ? MAX_PATTERN : len_q;
    n_take  = (it.byte_count > BYTES_PER_ITEM) ? BYTES_PER_ITEM : it.byte_count;
    if (!matched_q) begin
      for (int k = 0; k < n_take && !has_res; k++) begin
        recent_q = {recent_q[MAX_PATTERN-2:0], it.data_word[8*k +: 8]};
        if (seen_q != '1) seen_q++;
        if (seen_q >= span && window_hit(span)) begin
          has_res            = 1'b1;
          res.found          = 1'b1;
          res.match_offset   = (seen_q == '1) ? '1 : seen_q - span;
          matched_q          = 1'b1;
        end
      end
      // region ended with no hit: not-found result
      if (!has_res && it.last) has_res = 1'b1;
    end
    if (it.last) begin
      recent_q  = '0;
      seen_q    = '0;
      matched_q = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t res;
    bit        has_res;
    if (!rst_ni) begin
      pat_lo_q     = '0;
      pat_hi_q     = '0;
      care_q       = '0;
      len_q        = LEN_W'(1);
      recent_q     = '0;
      seen_q       = '0;
      matched_q    = 1'b0;
      fails        = 0;
      scanned      = 0;
      results_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      scanned_o    <= 0;
    end else begin
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (cfg_reg_e'(paddr_i[REG_SEL_LSB +: 2]))
          REG_PATTERN_LOW:    pat_lo_q = pwdata_i;
          REG_PATTERN_HIGH:   pat_hi_q = pwdata_i;
          REG_CARE_MASK:      care_q   = pwdata_i[CARE_W-1:0];
          REG_PATTERN_LENGTH: len_q    = pwdata_i[LEN_W-1:0];
          default: ;
        endcase
      end

      // output transfer against the oldest pending result
      if (out_valid_i && !out_stall_i) begin
        if (results_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got found=%0b offset=%0d",
                   $time, out_item_i.found, out_item_i.match_offset);
        end else begin
          want = results_q.pop_front();
          if (want.found !== out_item_i.found) begin
            fails++;
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_item_i.found);
          end
          if (want.match_offset !== out_item_i.match_offset) begin
            fails++;
            $display("%0t: match_offset mismatch, expected %0d, got %0d",
                     $time, want.match_offset, out_item_i.match_offset);
          end
        end
      end

      // input transfer
      if (in_valid_i && !in_stall_i) begin
        scanned++;
        scan_item(in_item_i, has_res, res);
        if (has_res) results_q.push_back(res);
      end

      fail_count_o <= fails;
      pending_o    <= results_q.size();
      scanned_o    <= scanned;
    end
  end

endmodule

// ===== sim/masked_pattern_search_tb.sv =====
`timescale 1ns / 100ps
// testbench top for masked_pattern_search: drives stream regions, register
// writes and output stalls; depends on mps_pkg, the block and mps_scan_check
module masked_pattern_search_tb;
  import mps_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [7:0] byte_q_t[$];

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [WORD_W-1:0] pwdata    = '0;
  logic [WORD_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int scanned;
  int stall_left  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;

  // what the pattern currently looks like, for planting matches
  logic [2*WORD_W-1:0] cur_pat  = '0;
  logic [CARE_W-1:0]   cur_care = '0;
  int unsigned         cur_span = 1;

  always #4 clk_i = ~clk_i;

  masked_pattern_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  mps_scan_check u_scan_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .scanned_o    (scanned)
  );

  // output stalls: free stretches, short stalls, a few long ones
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(30, 1);
        end
        4: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(200, 60);
        end
        5, 6, 7: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(3, 1);
        end
        8: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(12, 4);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(50, 20);
        end
      endcase
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte(bit narrow);
    if (narrow) return $urandom_range(1) ? 8'hA5 : 8'h5A;
    return 8'($urandom);
  endfunction

  // random bytes, optionally with the current pattern planted at a random spot
  function automatic byte_q_t build_stream(int n, bit plant, bit narrow);
    byte_q_t q;
    int      at;
    for (int i = 0; i < n; i++) q.push_back(pick_byte(narrow));
    if (plant && n >= cur_span) begin
      at = $urandom_range(n - cur_span);
      for (int i = 0; i < cur_span; i++) begin
        if (cur_care[i]) q[at+i] = cur_pat[8*i +: 8];
      end
    end
    return q;
  endfunction

  // one input transfer, after an optional gap; returns at the accepting edge
  task automatic send_item(logic [WORD_W-1:0] word, logic [CNT_W-1:0] cnt, logic fin);
    int gap;
    int r;
    gap = 0;
    if (!steady) begin
      r   = $urandom_range(99);
      gap = (r < 55) ? 0 : (r < 85) ? $urandom_range(3, 1) :
            (r < 97) ? $urandom_range(10, 4) : $urandom_range(60, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid           <= 1'b1;
    in_item.data_word  <= word;
    in_item.byte_count <= cnt;
    in_item.last       <= fin;
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
  endtask

  // cut a region into transfers: mostly full words, some short, empty or over-counted ones
  task automatic send_stream(byte_q_t strm);
    int                pos;
    int                take;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    pos    = 0;
    steady = ($urandom_range(4) == 0);
    do begin
      take = ($urandom_range(9) == 0) ? $urandom_range(8) : 8;
      if (take > strm.size() - pos) take = strm.size() - pos;
      word = {$urandom, $urandom};
      for (int b = 0; b < take; b++) word[8*b +: 8] = strm[pos+b];
      cnt = CNT_W'(take);
      if (take == 8 && $urandom_range(7) == 0) cnt = CNT_W'($urandom_range(15, 9));
      pos += take;
      send_item(word, cnt, pos >= strm.size());
    end while (pos < strm.size());
  endtask

  // stop input and wait until all results are out and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [WORD_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(r) << REG_SEL_LSB;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                            logic [CARE_W-1:0] care, logic [LEN_W-1:0] len);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, WORD_W'(care));
    write_reg(REG_PATTERN_LENGTH, WORD_W'(len));
    psel     <= 1'b0;
    penable  <= 1'b0;
    cur_pat  = {hi, lo};
    cur_care = care;
    cur_span = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : len;
  endtask

  initial begin
    logic [2*WORD_W-1:0] pat;
    logic [CARE_W-1:0]   care;
    logic [LEN_W-1:0]    len;
    bit                  narrow;
    int                  n;
    int                  r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config is all-wildcard length 1: hit at offset 0, rest ignored
    send_item({$urandom, $urandom}, 4'd8, 1'b0);
    send_item({$urandom, $urandom}, 4'd8, 1'b1);
    // empty region ends not-found
    send_item({$urandom, $urandom}, 4'd0, 1'b1);
    drain_results();

    // full 16 byte pattern, every byte cared for
    set_config('1, '0, '1, LEN_W'(MAX_PATTERN));
    send_stream(build_stream(30, 1'b1, 1'b0));
    // region too short to hold a match
    send_stream(build_stream(10, 1'b1, 1'b0));
    drain_results();

    // all-wildcard of length 5: short region misses, longer one hits at 0
    set_config({$urandom, $urandom}, {$urandom, $urandom}, '0, LEN_W'(5));
    send_stream(build_stream(3, 1'b0, 1'b0));
    send_stream(build_stream(12, 1'b0, 1'b0));
    drain_results();

    // oversized length acts as the maximum
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h8001, '1);
    send_stream(build_stream(40, 1'b1, 1'b0));
    drain_results();

    // length zero acts as one
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h0001, '0);
    send_stream(build_stream(20, 1'b1, 1'b0));
    drain_results();

    // register write in the middle of a region keeps the history
    set_config(64'h0, 64'h0, 16'h00FF, LEN_W'(8));
    send_item({$urandom, $urandom}, 4'd8, 1'b0);
    drain_results();
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h0003, LEN_W'(2));
    send_item({$urandom, $urandom}, 4'd15, 1'b0);
    send_item({$urandom, $urandom}, 4'd0, 1'b0);
    send_item({$urandom, $urandom}, 4'd3, 1'b1);
    drain_results();

    // random phases, each with its own settings
    while (scanned < ITEM_TARGET) begin
      narrow = ($urandom_range(9) < 3);
      for (int i = 0; i < MAX_PATTERN; i++) pat[8*i +: 8] = pick_byte(narrow);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: care = 16'($urandom);
        5, 6:          care = '1;
        7:             care = '0;
        default:       care = 16'($urandom & $urandom);
      endcase
      r = $urandom_range(9);
      if (r < 7) begin
        len = LEN_W'($urandom_range(MAX_PATTERN, 1));
      end else begin
        case ($urandom_range(3))
          0:       len = '0;
          1:       len = LEN_W'(MAX_PATTERN);
          2:       len = LEN_W'(MAX_PATTERN + 1);
          default: len = '1;
        endcase
      end
      set_config(pat[WORD_W-1:0], pat[2*WORD_W-1:WORD_W], care, len);

      repeat ($urandom_range(25, 10)) begin
        r = $urandom_range(99);
        n = (r < 80) ? $urandom_range(40) : (r < 95) ? $urandom_range(120, 41) :
            $urandom_range(300, 121);
        send_stream(build_stream(n, $urandom_range(9) < 6, narrow));
      end
      drain_results();
    end

    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
